[src/sau_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sau_pkg: shared types and constants of the Snake activation unit
// Sample and coefficient types, fixed-point constants and the Q30 sine
// series that is used at elaboration to build the sine-squared table.
// ----------------------------------------------------------------------------
package sau_pkg;

    // sample width (x and y, Q5.10) and coefficient width (a and r, Q3.12)
    localparam int DATA_WIDTH = 16;
    localparam int COEF_WIDTH = 16;

    typedef logic signed [DATA_WIDTH-1:0] t_sample;
    typedef logic signed [COEF_WIDTH-1:0] t_coef;

    // saturation limits of the result
    localparam t_sample SAMPLE_MAX = t_sample'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
    localparam t_sample SAMPLE_MIN = t_sample'(64'd1 << (DATA_WIDTH - 1));

    // pi in Q30, 1/pi in Q32, one in Q16
    localparam logic [63:0] PI_Q30     = 64'd3373259426;
    localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;
    localparam logic [16:0] ONE_Q16    = 17'h10000;

    // Taylor divisors (2n)(2n+1) for n = 1..7
    localparam logic [7:0] TAYLOR_DIV [1:7] = '{8'd6, 8'd20, 8'd42, 8'd72,
                                               8'd110, 8'd156, 8'd210};

    // sin(theta) in Q30 for theta in Q30 within the first quadrant
    function automatic logic [63:0] sine_q30(input logic [63:0] theta);
        logic [63:0] th2;
        logic [63:0] term;
        longint      sum;
        th2  = (theta * theta + (64'd1 << 29)) >> 30;
        term = theta;
        sum  = longint'(theta);
        for (int n = 1; n <= 7; n++) begin
            term = ((term * th2) >> 30) / 64'(TAYLOR_DIV[n]);
            if (n % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        return 64'(sum);
    endfunction

endpackage
`default_nettype wire

[src/snake_activation_unit_core.sv]
`default_nettype none
// Throughput: one beat per cycle; busy is held low, start is taken every cycle.
// Each beat passes through an eight-stage chain to the o_valid strobe: product,
// phase, table index, table read, two interpolation stages, gain product,
// rounding with saturation.
// Reset (synchronous, active low) clears the valid pipeline; beats in flight
// are dropped. The receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
// snake_activation_unit_core: y = x + r * sin(a*x)^2
// Phase reduction over one period of pi, interpolated sine-squared ROM,
// Q10 rounding of the correction and saturation to the sample range.
// ----------------------------------------------------------------------------
module snake_activation_unit_core #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              start,
    output logic             busy,
    input  sau_pkg::t_sample i_sample_in,
    input  sau_pkg::t_coef   i_freq,
    input  sau_pkg::t_coef   i_gain,
    output logic             o_valid,
    output sau_pkg::t_sample o_sample_out,
    output logic             o_saturated
);
    import sau_pkg::*;

    localparam int LAT        = 8;
    localparam int ADDR_W     = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int POS_W      = 32 + ADDR_W;
    localparam int HALF_DEPTH = SINE_TABLE_DEPTH / 2;
    localparam int Y_W        = DATA_WIDTH + 1;

    typedef logic [16:0] t_sq_table [0:SINE_TABLE_DEPTH];

    // sine-squared over one period, Q16, built at elaboration
    function automatic t_sq_table build_sq_table();
        t_sq_table   tab;
        logic [63:0] kk;
        logic [63:0] theta;
        logic [63:0] s;
        logic [63:0] s2;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            kk    = (2 * k <= SINE_TABLE_DEPTH) ? 64'(k) : 64'(SINE_TABLE_DEPTH - k);
            theta = (PI_Q30 * kk + 64'(HALF_DEPTH)) / SINE_TABLE_DEPTH;
            s     = sine_q30(theta);
            s2    = (s * s + (64'd1 << 43)) >> 44;
            if (s2 > 64'(ONE_Q16)) begin
                s2 = 64'(ONE_Q16);
            end
            tab[k] = s2[16:0];
        end
        return tab;
    endfunction

    localparam t_sq_table SQ_TABLE = build_sq_table();

    logic            w_accept;
    logic [LAT-1:0]  r_vld;
    t_sample         r_x_d [0:LAT-2];
    t_coef           r_r_d [0:LAT-3];

    logic signed [31:0] r_p;
    logic [31:0]        w_mag;
    logic [61:0]        w_phase;
    logic [31:0]        r_frac;
    logic [POS_W-1:0]   w_pos;
    logic [ADDR_W-1:0]  r_idx;
    logic [ADDR_W-1:0]  w_idx_nxt;
    logic [15:0]        r_w3;
    logic [15:0]        r_w4;
    logic [16:0]        r_t0;
    logic [16:0]        r_t1;
    logic [16:0]        w_wc;
    logic [33:0]        r_prod0;
    logic [33:0]        r_prod1;
    logic [33:0]        w_isum;
    logic [16:0]        r_s2;
    logic [15:0]        w_rabs;
    logic [32:0]        r_cm_raw;
    logic               r_neg;
    logic [32:0]        w_cm_rnd;
    logic [13:0]        w_cm;
    logic signed [Y_W-1:0] w_corr;
    logic signed [Y_W-1:0] w_y;
    t_sample            r_sample_out;
    logic               r_saturated;

    // no backpressure: every start is a beat
    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    // valid bits travel with the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], w_accept};
        end
    end

    // delay lines for x and r
    always_ff @(posedge i_clk) begin
        r_x_d[0] <= i_sample_in;
        r_r_d[0] <= i_gain;
        for (int k = 1; k <= LAT - 2; k++) begin
            r_x_d[k] <= r_x_d[k-1];
        end
        for (int k = 1; k <= LAT - 3; k++) begin
            r_r_d[k] <= r_r_d[k-1];
        end
    end

    // stage 1: exact product a*x, Q9.22
    always_ff @(posedge i_clk) begin
        r_p <= 32'(i_freq) * 32'(i_sample_in);
    end

    // stage 2: |a*x| / pi, keep the Q32 fraction of periods
    assign w_mag   = r_p[31] ? (32'd0 - 32'(r_p)) : 32'(r_p);
    assign w_phase = 62'(w_mag[30:0]) * 62'(INV_PI_Q32);

    always_ff @(posedge i_clk) begin
        r_frac <= w_phase[53:22];
    end

    // stage 3: table index and Q16 weight (index is below depth by construction)
    assign w_pos = POS_W'(r_frac) * POS_W'(SINE_TABLE_DEPTH);

    always_ff @(posedge i_clk) begin
        r_idx <= w_pos[32 +: ADDR_W];
        r_w3  <= w_pos[31:16];
    end

    // stage 4: read both neighbors
    assign w_idx_nxt = r_idx + ADDR_W'(1);

    always_ff @(posedge i_clk) begin
        r_t0 <= SQ_TABLE[r_idx];
        r_t1 <= SQ_TABLE[w_idx_nxt];
        r_w4 <= r_w3;
    end

    // stage 5: weighted products
    assign w_wc = ONE_Q16 - {1'b0, r_w4};

    always_ff @(posedge i_clk) begin
        r_prod0 <= 34'(r_t0) * 34'(w_wc);
        r_prod1 <= 34'(r_t1) * 34'({1'b0, r_w4});
    end

    // stage 6: sum and round to Q16
    assign w_isum = r_prod0 + r_prod1 + 34'(1 << 15);

    always_ff @(posedge i_clk) begin
        r_s2 <= w_isum[32:16];
    end

    // stage 7: |r| * s2, Q28
    assign w_rabs = r_r_d[LAT-3][COEF_WIDTH-1] ? (16'd0 - 16'(r_r_d[LAT-3]))
                                              : 16'(r_r_d[LAT-3]);

    always_ff @(posedge i_clk) begin
        r_cm_raw <= 33'(w_rabs) * 33'(r_s2);
        r_neg    <= r_r_d[LAT-3][COEF_WIDTH-1];
    end

    // stage 8: round half away from zero to Q10, add x, saturate
    assign w_cm_rnd = r_cm_raw + 33'(1 << 17);
    assign w_cm     = w_cm_rnd[31:18];
    assign w_corr   = r_neg ? (Y_W'(0) - Y_W'(w_cm)) : Y_W'(w_cm);
    assign w_y      = Y_W'(r_x_d[LAT-2]) + w_corr;

    always_ff @(posedge i_clk) begin
        if (w_y > Y_W'(SAMPLE_MAX)) begin
            r_sample_out <= SAMPLE_MAX;
            r_saturated  <= 1'b1;
        end else if (w_y < Y_W'(SAMPLE_MIN)) begin
            r_sample_out <= SAMPLE_MIN;
            r_saturated  <= 1'b1;
        end else begin
            r_sample_out <= w_y[DATA_WIDTH-1:0];
            r_saturated  <= 1'b0;
        end
    end

    assign o_valid      = r_vld[LAT-1];
    assign o_sample_out = r_sample_out;
    assign o_saturated  = r_saturated;

    // every accepted beat comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LAT o_valid)
        else $error("accepted beat did not reach the output");

    // no result strobe without a matching accepted beat
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, LAT))
        else $error("result strobe without accepted beat");

    // zero gain passes x through unclipped
    a_zero_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_gain == '0)) |->
            ##LAT (o_sample_out == $past(i_sample_in, LAT) && !o_saturated))
        else $error("zero gain did not pass sample through");

    // clipped results sit on a limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_sample_out == SAMPLE_MAX || o_sample_out == SAMPLE_MIN))
        else $error("saturation flag without limit value");

    // interpolated sine squared never exceeds one
    a_s2_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] |-> (r_s2 <= ONE_Q16))
        else $error("interpolated sine squared out of range");

endmodule
`default_nettype wire

[tb/snake_activation_unit_core_tb.sv]
// ----------------------------------------------------------------------------
// snake_activation_unit_core_tb: self-checking bench for the Snake activation
// Drives x, a and r beats through the start/busy command port, predicts
// y = x + r*sin(a*x)^2 with a bit-true fixed-point model and checks every
// o_valid strobe in order. Directed corner beats first, then random beats
// under three sender idle settings.
// ----------------------------------------------------------------------------
module snake_activation_unit_core_tb;

    import sau_pkg::t_sample;
    import sau_pkg::t_coef;

    localparam int          SQ_DEPTH     = 256;
    localparam logic [63:0] PI_Q30_TB    = 64'd3373259426;
    localparam logic [63:0] RECIP_PI_Q32 = 64'd1367130551;
    localparam logic [63:0] UNIT_Q16     = 64'd65536;
    localparam longint      Y_MAX        = 32767;
    localparam longint      Y_MIN        = -32768;
    localparam int          PIPE_DEPTH   = 8;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          BEATS_PHASE  = 410;

    typedef struct packed {
        t_sample y;
        logic    sat;
    } t_snake_beat;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_sample  i_sample_in;
    t_coef    i_freq;
    t_coef    i_gain;
    logic     o_valid;
    t_sample  o_sample_out;
    logic     o_saturated;

    // sin^2 over one period, unsigned Q16
    logic [16:0]  sq_rom [0:SQ_DEPTH];
    t_snake_beat  pending_snake_q[$];
    int           mismatch_count;
    int           beats_sent;
    int           beats_checked;
    int           clipped_seen;
    int           cycle_count;

    snake_activation_unit_core #(
        .SINE_TABLE_DEPTH(SQ_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_sample_in (i_sample_in),
        .i_freq      (i_freq),
        .i_gain      (i_gain),
        .o_valid     (o_valid),
        .o_sample_out(o_sample_out),
        .o_saturated (o_saturated)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Q30 sine, first quadrant, 8-term Taylor series
    function automatic logic [63:0] quarter_sine_q30(input logic [63:0] theta);
        logic [63:0] th_sq;
        logic [63:0] term;
        longint      acc;
        th_sq = (theta * theta + (64'd1 << 29)) >> 30;
        term  = theta;
        acc   = longint'(theta);
        for (int n = 1; n <= 7; n++) begin
            term = ((term * th_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        return 64'(acc);
    endfunction

    task automatic build_sq_rom();
        logic [63:0] kk;
        logic [63:0] theta;
        logic [63:0] s;
        logic [63:0] s_sq;
        for (int k = 0; k <= SQ_DEPTH; k++) begin
            // mirror about the peak so both halves match exactly
            kk    = (2 * k <= SQ_DEPTH) ? 64'(k) : 64'(SQ_DEPTH - k);
            theta = (PI_Q30_TB * kk + 64'(SQ_DEPTH / 2)) / 64'(SQ_DEPTH);
            s     = quarter_sine_q30(theta);
            s_sq  = (s * s + (64'd1 << 43)) >> 44;
            if (s_sq > UNIT_Q16) begin
                s_sq = UNIT_Q16;
            end
            sq_rom[k] = s_sq[16:0];
        end
    endtask

    // y = x + r*sin(a*x)^2, saturated
    function automatic t_snake_beat predict_snake(input t_sample x, input t_coef a,
                                                  input t_coef r);
        longint      prod;
        longint      r_val;
        longint      corr;
        longint      y;
        logic [63:0] mag;
        logic [63:0] phase;
        logic [63:0] pos;
        logic [63:0] idx;
        logic [63:0] w;
        logic [63:0] s_sq;
        logic [63:0] cm;
        t_snake_beat res;
        prod  = longint'(x) * longint'(a);
        mag   = (prod < 0) ? 64'(-prod) : 64'(prod);
        // phase in periods of pi, fraction kept in Q32
        phase = ((mag * RECIP_PI_Q32) & ((64'd1 << 54) - 64'd1)) >> 22;
        pos   = phase * 64'(SQ_DEPTH);
        idx   = pos >> 32;
        if (idx >= 64'(SQ_DEPTH)) begin
            idx = 64'(SQ_DEPTH - 1);
        end
        w     = (pos >> 16) & 64'hFFFF;
        s_sq  = (64'(sq_rom[int'(idx)]) * (UNIT_Q16 - w) +
                 64'(sq_rom[int'(idx) + 1]) * w + (64'd1 << 15)) >> 16;
        // Q28 correction rounded half away from zero to Q10
        r_val = longint'(r);
        cm    = 64'((r_val < 0) ? -r_val : r_val) * s_sq;
        cm    = (cm + (64'd1 << 17)) >> 18;
        corr  = (r_val < 0) ? -longint'(cm) : longint'(cm);
        y     = longint'(x) + corr;
        res.sat = 1'b0;
        if (y > Y_MAX) begin
            y       = Y_MAX;
            res.sat = 1'b1;
        end
        if (y < Y_MIN) begin
            y       = Y_MIN;
            res.sat = 1'b1;
        end
        res.y = t_sample'(y);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // one beat: hold start and fields until taken; start stays high afterwards
    task automatic send_beat(input t_sample x, input t_coef a, input t_coef r);
        @(negedge i_clk);
        start       = 1'b1;
        i_sample_in = x;
        i_freq      = a;
        i_gain      = r;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_snake_q = {pending_snake_q, predict_snake(x, a, r)};
        beats_sent++;
    endtask

    task automatic idle_cycle();
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic sender_gaps(input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            idle_cycle();
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_snake_q.size() == 0) begin
                report_mismatch("strobe with no beat outstanding",
                                longint'(o_sample_out), 0);
            end else begin
                t_snake_beat want;
                want = pending_snake_q.pop_front();
                beats_checked++;
                if (o_sample_out !== want.y) begin
                    report_mismatch("sample_out", longint'(o_sample_out), longint'(want.y));
                end
                if (o_saturated !== want.sat) begin
                    report_mismatch("saturated", longint'(o_saturated), longint'(want.sat));
                end
                if (want.sat) begin
                    clipped_seen++;
                end
            end
        end
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
                 pending_snake_q.size());
        $display("FAILURE");
        $finish;
    end

    // corners: zero a or r, extreme operands, clipping both ways, sin^2 peak and zero
    task automatic test_directed();
        send_beat(16'sd0, 16'sd0, 16'sd0);
        send_beat(16'sh7FFF, 16'sd0, 16'sh7FFF);
        send_beat(16'sh8000, 16'sh7FFF, 16'sd0);
        send_beat(16'sh8000, 16'sh8000, 16'sh8000);
        send_beat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_beat(16'sh8000, 16'sh7FFF, 16'sh8000);
        send_beat(16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_beat(16'sh7FFF, 16'sh8000, 16'sh8000);
        send_beat(16'sd1024, 16'sd4096, 16'sd4096);
        send_beat(-16'sd1024, 16'sd4096, -16'sd4096);
        send_beat(16'sd1, 16'sd1, 16'sd1);
        send_beat(-16'sd1, -16'sd1, -16'sd1);
        // a*x near pi/2: sin^2 close to one
        send_beat(16'sd1608, 16'sd4096, 16'sh7FFF);
        // a*x near pi: sin^2 close to zero
        send_beat(16'sd3217, 16'sd4096, 16'sh7FFF);
        send_beat(16'sd30000, 16'sd4096, 16'sh7FFF);
        send_beat(-16'sd30000, 16'sd4096, 16'sh8000);
        send_beat(16'sh5555, 16'shAAAA, 16'sh5555);
        send_beat(16'shAAAA, 16'sh5555, 16'shAAAA);
        send_beat(16'sh7FFF, 16'sd0, 16'sd0);
        send_beat(16'sh8000, 16'sd0, 16'sh7FFF);
    endtask

    task automatic test_random(input int n_beats, input int idle_pct);
        t_sample x;
        t_coef   a;
        t_coef   r;
        for (int i = 0; i < n_beats; i++) begin
            x = t_sample'($urandom);
            a = t_coef'($urandom);
            r = t_coef'($urandom);
            case ($urandom_range(9))
                0: a = '0;
                1: r = '0;
                2: begin
                    // near the rails with a correction pushing outward
                    if ($urandom_range(1)) begin
                        x = t_sample'(32767 - $urandom_range(3000));
                        r = t_coef'($urandom_range(32767, 8192));
                    end else begin
                        x = t_sample'(-32768 + $urandom_range(3000));
                        r = t_coef'(-$urandom_range(32768, 8192));
                    end
                end
                3: begin
                    x = t_sample'($urandom_range(8191) - 4096);
                    a = t_coef'($urandom_range(16383) - 8192);
                end
                default: ;
            endcase
            sender_gaps(idle_pct);
            send_beat(x, a, r);
        end
    endtask

    initial begin
        int directed_beats;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_sample_in    = '0;
        i_freq         = '0;
        i_gain         = '0;
        mismatch_count = 0;
        beats_sent     = 0;
        beats_checked  = 0;
        clipped_seen   = 0;
        build_sq_rom();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        directed_beats = beats_sent;
        test_random(BEATS_PHASE, 28);
        test_random(BEATS_PHASE, 72);
        test_random(BEATS_PHASE, 0);

        @(negedge i_clk);
        start = 1'b0;
        while (pending_snake_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2 * PIPE_DEPTH) @(posedge i_clk);

        $display("checked %0d of %0d beats (%0d directed corners), %0d clipped results",
                 beats_checked, beats_sent, directed_beats, clipped_seen);
        $display("sender idle at 28, 72 and 0 percent; %0d mismatches", mismatch_count);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
